@@ hw/rtl/xmodem_crc_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver assertion macros
// Property shorthands on clk with the synchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CRC_RECEIVER_ASSERT_SVH
`define XMODEM_CRC_RECEIVER_ASSERT_SVH

// Same-cycle implication.
`define XCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xcr: same-cycle check failed");

// Next-cycle implication.
`define XCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xcr: next-cycle check failed");

`endif

@@ hw/rtl/xcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared widths, command and byte codes, result record and the CRC step.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int FILL_W       = 13;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 4'd1;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_ETB = 8'h17;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0]        send_byte;
    logic              rd_hit;
    logic [FILL_W-1:0] fill;
    logic              ovf;
  } result_t;

  // CRC-16, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/xcr_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface xcr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [7:0]                rx_byte;
  logic [xcr_pkg::ADDR_W-1:0] read_addr;

  modport source (output valid, output cmd, output rx_byte, output read_addr, input ready);
  modport sink   (input valid, input cmd, input rx_byte, input read_addr, output ready);
endinterface

@@ hw/rtl/xcr_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface xcr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       send_valid;
  logic [7:0]                 send_byte;
  logic [7:0]                 read_data;
  logic [xcr_pkg::FILL_W-1:0] buffer_fill;
  logic                       overflow;

  modport source (output valid, output send_valid, output send_byte, output read_data,
                  output buffer_fill, output overflow, input ready);
  modport sink   (input valid, input send_valid, input send_byte, input read_data,
                  input buffer_fill, input overflow, output ready);
endinterface

@@ hw/rtl/xcr_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver configuration channel
// Valid/ready register write channel: index and write data.
// ----------------------------------------------------------------------------
interface xcr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [xcr_pkg::CFG_IDX_W-1:0]  index;
  logic [xcr_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/xcr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module xcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/xcr_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver protocol engine
// Packet walk, CRC, timeout and retry state; payload writes to the buffer RAM.
// ----------------------------------------------------------------------------
module xcr_engine #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [xcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           item_go,
  input  xcr_pkg::cmd_t                  cmd,
  input  logic [7:0]                     rx_byte,
  input  logic [xcr_pkg::ADDR_W-1:0]     read_addr,
  output logic                           mem_we,
  output logic [xcr_pkg::ADDR_W-1:0]     mem_waddr,
  output logic [7:0]                     mem_wdata,
  output xcr_pkg::result_t               result
);
  import xcr_pkg::*;

  localparam int PH_W  = $clog2(PAYLOAD_BYTES + 5);
  localparam int PC_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int SUM_W = $clog2(BUFFER_BYTES + PAYLOAD_BYTES + 1);

  localparam logic [PH_W-1:0]  PH_IDLE   = PH_W'(0);
  localparam logic [PH_W-1:0]  PH_SEQ    = PH_W'(1);
  localparam logic [PH_W-1:0]  PH_INV    = PH_W'(2);
  localparam logic [PH_W-1:0]  PH_CRC_HI = PH_W'(PAYLOAD_BYTES + 3);
  localparam logic [PH_W-1:0]  PH_CRC_LO = PH_W'(PAYLOAD_BYTES + 4);
  localparam logic [SUM_W-1:0] BUF_LIM   = SUM_W'(BUFFER_BYTES);
  localparam logic [PC_W-1:0]  PC_MAX    = PC_W'(PAYLOAD_BYTES);

  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [PC_W-1:0]   pcnt_r, pcnt_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [7:0]        last_r, last_nxt;
  logic [15:0]       countdown_r, countdown_nxt;
  logic [3:0]        retry_r, retry_nxt;
  logic [15:0]       timeout_r, timeout_nxt;
  logic [3:0]        limit_r, limit_nxt;

  logic [SUM_W-1:0]  sum;
  logic [15:0]       cd_dec;
  logic [3:0]        retry_inc;
  logic [7:0]        resp;
  logic [7:0]        send;

  always_comb begin
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    crc_nxt       = crc_r;
    pcnt_nxt      = pcnt_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    countdown_nxt = countdown_r;
    retry_nxt     = retry_r;
    timeout_nxt   = timeout_r;
    limit_nxt     = limit_r;
    resp          = 8'h00;
    send          = 8'h00;
    mem_we        = 1'b0;
    sum           = SUM_W'(fill_r) + SUM_W'(pcnt_r);
    mem_waddr     = sum[ADDR_W-1:0];
    mem_wdata     = rx_byte;
    cd_dec        = (countdown_r != 16'd0) ? countdown_r - 16'd1 : 16'd0;
    retry_inc     = retry_r + 4'd1;

    if (cfg_we) begin
      if (cfg_idx == CFG_TIMEOUT) begin
        timeout_nxt = cfg_wdata;
      end else if (cfg_idx == CFG_RETRY) begin
        limit_nxt = cfg_wdata[3:0];
      end
    end

    if (item_go) begin
      case (cmd)
        CMD_BYTE: begin
          countdown_nxt = timeout_r;
          if (phase_r == PH_IDLE) begin
            case (rx_byte)
              B_SOH: begin
                crc_nxt   = 16'h0000;
                pcnt_nxt  = '0;
                phase_nxt = PH_SEQ;
              end
              B_EOT, B_ETB: begin
                resp     = B_ACK;
                seq_nxt  = 8'd1;
                fill_nxt = '0;
                ovf_nxt  = 1'b0;
              end
              B_CAN: begin
                resp     = B_C;
                seq_nxt  = 8'd1;
                fill_nxt = '0;
                ovf_nxt  = 1'b0;
              end
              default: begin
                resp = B_NAK;
              end
            endcase
          end else if (phase_r == PH_SEQ) begin
            if (rx_byte != seq_r) begin
              phase_nxt = PH_IDLE;
              resp      = B_NAK;
            end else begin
              phase_nxt = PH_INV;
            end
          end else if (phase_r == PH_INV) begin
            if (rx_byte != ~seq_r) begin
              phase_nxt = PH_IDLE;
              resp      = B_NAK;
            end else begin
              phase_nxt = phase_r + PH_W'(1);
            end
          end else if (phase_r == PH_CRC_HI) begin
            if (rx_byte != crc_r[15:8]) begin
              phase_nxt = PH_IDLE;
              resp      = B_NAK;
            end else begin
              phase_nxt = PH_CRC_LO;
            end
          end else if (phase_r == PH_CRC_LO) begin
            phase_nxt = PH_IDLE;
            if (rx_byte != crc_r[7:0]) begin
              resp = B_NAK;
            end else begin
              // commit: payload already sits above the fill mark
              resp    = B_ACK;
              seq_nxt = seq_r + 8'd1;
              if (sum > BUF_LIM) begin
                fill_nxt = FILL_W'(BUFFER_BYTES);
                ovf_nxt  = 1'b1;
              end else begin
                fill_nxt = sum[FILL_W-1:0];
              end
            end
          end else begin
            crc_nxt   = crc16_byte(crc_r, rx_byte);
            phase_nxt = phase_r + PH_W'(1);
            if (pcnt_r < PC_MAX) begin
              pcnt_nxt = pcnt_r + PC_W'(1);
              mem_we   = (sum < BUF_LIM);
            end
          end
          last_nxt = resp;
          send     = resp;
        end
        CMD_TICK: begin
          if (cd_dec == 16'd0) begin
            countdown_nxt = timeout_r;
            send          = last_r;
            retry_nxt     = retry_inc;
            if (retry_inc >= limit_r) begin
              last_nxt  = B_C;
              seq_nxt   = 8'd1;
              phase_nxt = PH_IDLE;
              retry_nxt = 4'd0;
            end
          end else begin
            countdown_nxt = cd_dec;
          end
        end
        default: begin
        end
      endcase
    end

    result.send_byte = send;
    // read offsets are always below the buffer size, so only the fill bounds them
    result.rd_hit    = item_go && (cmd == CMD_READ) && (FILL_W'(read_addr) < fill_r);
    result.fill      = fill_nxt;
    result.ovf       = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_r       <= 8'd1;
      crc_r       <= 16'h0000;
      pcnt_r      <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      last_r      <= B_C;
      countdown_r <= 16'd0;
      retry_r     <= 4'd0;
      timeout_r   <= 16'd3000;
      limit_r     <= 4'd3;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      crc_r       <= crc_nxt;
      pcnt_r      <= pcnt_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      countdown_r <= countdown_nxt;
      retry_r     <= retry_nxt;
      timeout_r   <= timeout_nxt;
      limit_r     <= limit_nxt;
    end
  end

endmodule

@@ hw/rtl/xmodem_crc_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver
// Packet checker with CRC-16, ACK/NAK/'C' responses and a committed byte buffer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transfer when      | Carries
//  --------+-----------+--------------------+------------------------------------------
//  in_ch   | sink      | valid && ready     | cmd, rx_byte, read_addr
//  out_ch  | source    | valid && ready     | send_valid, send_byte, read_data,
//          |           |                    | buffer_fill, overflow
//  cfg_ch  | sink      | valid (ready is 1) | index, wdata (0 timeout_ticks, 1 retry_limit)
//
//  One item per cycle while the output does not stall. The engine updates all
//  session state in the accept cycle; a read is issued to the buffer RAM then
//  and its data returns in the next cycle. The result passes the result stage
//  and then the output register before out_ch.valid rises.
//  Reset clears session and pipeline control; buffer RAM content is never cleared,
//  entries at or above the fill mark read as zero.
//  A stalled output holds the result stage, which holds the RAM read data.
//
module xmodem_crc_receiver #(
  parameter int PAYLOAD_BYTES = 128
) (
  input logic       clk,
  input logic       rst_n,
  xcr_in_if.sink    in_ch,
  xcr_out_if.source out_ch,
  xcr_cfg_if.sink   cfg_ch
);
  import xcr_pkg::*;

  `include "xmodem_crc_receiver_assert.svh"

  logic              accept;
  logic              in_ready;
  logic              p1_move;
  cmd_t              cmd;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        ram_rdata;
  result_t           eng_res;

  // result stage: waits for the RAM read data
  logic              p1_valid_r, p1_valid_nxt;
  result_t           p1_res_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_send_valid_r;
  logic [7:0]        out_send_byte_r;
  logic [7:0]        out_read_data_r;
  logic [FILL_W-1:0] out_fill_r;
  logic              out_ovf_r;

  assign cmd      = cmd_t'(in_ch.cmd);
  assign p1_move  = p1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !p1_valid_r || p1_move;
  assign accept   = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  xcr_engine #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_idx   (cfg_ch.index),
    .cfg_wdata (cfg_ch.wdata),
    .item_go   (accept),
    .cmd       (cmd),
    .rx_byte   (in_ch.rx_byte),
    .read_addr (in_ch.read_addr),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .result    (eng_res)
  );

  // payload lands above the fill mark, so a read never races a write it can see
  xcr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buffer (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept && (cmd == CMD_READ)),
    .raddr (in_ch.read_addr),
    .rdata (ram_rdata)
  );

  // advance on accept, drop once moved to the output register
  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (accept) begin
      p1_valid_nxt = 1'b1;
    end else if (p1_move) begin
      p1_valid_nxt = 1'b0;
    end
  end

  // hold until the transfer on out_ch completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_res_r <= eng_res;
    end
    if (p1_move) begin
      out_send_valid_r <= (p1_res_r.send_byte != 8'h00);
      out_send_byte_r  <= p1_res_r.send_byte;
      out_read_data_r  <= p1_res_r.rd_hit ? ram_rdata : 8'h00;
      out_fill_r       <= p1_res_r.fill;
      out_ovf_r        <= p1_res_r.ovf;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.send_valid  = out_send_valid_r;
  assign out_ch.send_byte   = out_send_byte_r;
  assign out_ch.read_data   = out_read_data_r;
  assign out_ch.buffer_fill = out_fill_r;
  assign out_ch.overflow    = out_ovf_r;

  `XCR_ASSERT_NEXT(a_accept_fills_stage, accept, p1_valid_r)
  `XCR_ASSERT_NEXT(a_rdata_held_on_stall, p1_valid_r && p1_res_r.rd_hit && !p1_move,
                   $stable(ram_rdata))
  `XCR_ASSERT_SAME(a_send_flag_matches, out_valid_r, out_send_valid_r == (out_send_byte_r != 8'h00))
  `XCR_ASSERT_SAME(a_read_sends_nothing, out_valid_r && (out_read_data_r != 8'h00), !out_send_valid_r)
  `XCR_ASSERT_SAME(a_overflow_means_full, out_valid_r && out_ovf_r, out_fill_r == FILL_W'(BUFFER_BYTES))

endmodule
